/* rtl/fvat_pkg.sv */
// ----------------------------------------------------------------------------
// fvat_pkg
// Shared types, widths and constants of the frequency and voltage auto-tuner.
// ----------------------------------------------------------------------------
package fvat_pkg;

    localparam int HISTORY_DEPTH = 30;
    localparam int WAIT_TICKS    = 25;

    localparam int HIST_IDX_W = (HISTORY_DEPTH > 2) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int RATE_W     = 24;
    localparam int FREQ_W     = 15;
    localparam int VOLT_W     = 15;
    localparam int POWER_W    = 12;
    localparam int FAN_W      = 7;
    localparam int TEMP_W     = 12;
    localparam int MODE_W     = 2;
    localparam int COUNT_W    = 6;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    // signed working width for the step and clamp arithmetic
    localparam int ARITH_W    = FREQ_W + 2;

    localparam int FREQ_FLOOR        = 4000;
    localparam int VOLT_FLOOR        = 10000;
    localparam int VOLT_INC          = 1;
    localparam int FREQ_STEP_WARMUP  = 5;
    localparam int FREQ_STEP_WORKING = 2;
    localparam int POWER_OVERSHOOT   = 2;
    localparam int FAN_OVERSHOOT     = 5;

    // tuning modes
    localparam logic [MODE_W-1:0] MODE_WAIT    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WARMUP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORKING = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_FREQ  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_VOLT  = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_LIMIT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_LIMIT   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLT    = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FREQ    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHIP_T  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_REG_T   = 4'd7;

    // register reset values
    localparam logic [FREQ_W-1:0]  RST_START_FREQ  = 15'd5250;
    localparam logic [VOLT_W-1:0]  RST_START_VOLT  = 15'd11500;
    localparam logic [POWER_W-1:0] RST_POWER_LIMIT = 12'd200;
    localparam logic [FAN_W-1:0]   RST_FAN_LIMIT   = 7'd75;
    localparam logic [VOLT_W-1:0]  RST_MAX_VOLT    = 15'd14000;
    localparam logic [FREQ_W-1:0]  RST_MAX_FREQ    = 15'd10000;
    localparam logic signed [TEMP_W-1:0] RST_MAX_CHIP_T = 12'sd650;
    localparam logic signed [TEMP_W-1:0] RST_MAX_REG_T  = 12'sd850;

    typedef struct packed {
        logic [RATE_W-1:0]         hashrate;
        logic                      temp_valid;
        logic signed [TEMP_W-1:0]  chip_temp_a;
        logic signed [TEMP_W-1:0]  chip_temp_b;
        logic signed [TEMP_W-1:0]  regulator_temp;
        logic [POWER_W-1:0]        power_now;
        logic [FAN_W-1:0]          fan_percent;
    } in_item_t;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency_out;
        logic [VOLT_W-1:0] voltage_out;
        logic [MODE_W-1:0] mode;
        logic              voltage_turn;
    } out_item_t;

    // history chain control
    typedef struct packed {
        logic load;   // take in a new hashrate
        logic scan;   // rotate one place and compare the tail
    } hist_ctrl_t;

endpackage

/* rtl/frequency_voltage_auto_tuner.sv */
// ----------------------------------------------------------------------------
// frequency_voltage_auto_tuner
// Once the wait mode is over, steps the working frequency or voltage up per
// poll tick while all measurements are under their limits, backs both off on
// a critical overshoot, and clamps them to floors and maxima.
// ----------------------------------------------------------------------------
//  channel   direction  handshake             payload
//  s_        in         s_valid / s_ready     in_item_t  (one poll tick)
//  m_        out        m_valid / m_ready     out_item_t (tuned settings)
//  cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
//  For each request the history chain rotates one cell per cycle past a
//  single comparator, then the DONE state updates the settings.
//  Reset is synchronous, active low; the history cells hold no reset and are
//  filled by the first request. A waiting result holds only the DONE state
//  of the following request; the next request is accepted meanwhile.
// ----------------------------------------------------------------------------
module frequency_voltage_auto_tuner
    import fvat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [HIST_IDX_W-1:0] cnt_reg, cnt_next;
    in_item_t              item_reg;
    out_item_t             out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic [POWER_W-1:0] power_limit_reg;
    logic [FAN_W-1:0]   fan_limit_reg;
    logic [VOLT_W-1:0]  max_volt_reg;
    logic [FREQ_W-1:0]  max_freq_reg;
    logic signed [TEMP_W-1:0] max_chip_t_reg;
    logic signed [TEMP_W-1:0] max_reg_t_reg;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               vsel_reg, vsel_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [VOLT_W-1:0]  volt_reg, volt_next;

    logic       s_accept, cfg_accept, commit;
    hist_ctrl_t hist_ctrl;
    logic       rose;

    logic hit, critical, can_rise, do_adjust;
    logic signed [ARITH_W-1:0] fstep, f_cur, v_cur, f_adj, v_adj;
    logic signed [ARITH_W-1:0] f_lo, f_hi, v_lo, v_hi, f_clamp, v_clamp;
    logic vsel_turn, vsel_adj;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign commit     = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign hist_ctrl.load = s_accept;
    assign hist_ctrl.scan = (state_reg == ST_SCAN);

    fvat_history u_history (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (hist_ctrl),
        .rate    (s_data.hashrate),
        .rose    (rose)
    );

    // sequencing
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (commit) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // limit checks
    always_comb begin
        hit = (item_reg.fan_percent > fan_limit_reg)
           || (item_reg.power_now > power_limit_reg)
           || (item_reg.chip_temp_a > max_chip_t_reg)
           || (item_reg.chip_temp_b > max_chip_t_reg);
        critical = (item_reg.chip_temp_a > max_chip_t_reg)
                || (item_reg.chip_temp_b > max_chip_t_reg)
                || ({1'b0, item_reg.power_now}
                    >= ({1'b0, power_limit_reg} + (POWER_W+1)'(POWER_OVERSHOOT)))
                || ({1'b0, item_reg.fan_percent}
                    >= ({1'b0, fan_limit_reg} + (FAN_W+1)'(FAN_OVERSHOOT)))
                || (item_reg.regulator_temp > max_reg_t_reg);
        can_rise = (item_reg.fan_percent < fan_limit_reg)
                && (item_reg.power_now < power_limit_reg)
                && (item_reg.chip_temp_a < max_chip_t_reg)
                && (item_reg.chip_temp_b < max_chip_t_reg)
                && (item_reg.regulator_temp < max_reg_t_reg);
    end

    // step and clamp
    always_comb begin
        fstep = (mode_reg == MODE_WARMUP) ? ARITH_W'(FREQ_STEP_WARMUP)
                                          : ARITH_W'(FREQ_STEP_WORKING);
        f_cur = $signed({2'b00, freq_reg});
        v_cur = $signed({2'b00, volt_reg});
        vsel_turn = rose ? vsel_reg : !vsel_reg;
        priority if (critical) begin
            f_adj = f_cur - fstep;
            v_adj = v_cur - ARITH_W'(VOLT_INC);
        end else if (can_rise && !vsel_turn) begin
            f_adj = f_cur + fstep;
            v_adj = v_cur;
        end else if (can_rise) begin
            f_adj = f_cur;
            v_adj = v_cur + ARITH_W'(VOLT_INC);
        end else begin
            f_adj = f_cur;
            v_adj = v_cur;
        end
        f_lo = ARITH_W'(FREQ_FLOOR);
        f_hi = $signed({2'b00, max_freq_reg});
        v_lo = ARITH_W'(VOLT_FLOOR);
        v_hi = $signed({2'b00, max_volt_reg});
        f_clamp = (f_adj < f_lo) ? f_lo : ((f_adj > f_hi) ? f_hi : f_adj);
        v_clamp = (v_adj < v_lo) ? v_lo : ((v_adj > v_hi) ? v_hi : v_adj);
        vsel_adj = (f_clamp == f_lo) || (v_clamp == v_lo) || vsel_turn;
    end

    // mode and settings
    always_comb begin
        mode_next  = mode_reg;
        count_next = count_reg;
        do_adjust  = 1'b0;
        unique case (mode_reg)
            MODE_WAIT: begin
                if (item_reg.temp_valid) begin
                    if (count_reg != '0) begin
                        count_next = count_reg - 1'b1;
                    end else if (item_reg.hashrate != '0) begin
                        mode_next = MODE_WARMUP;
                    end
                end
            end
            MODE_WARMUP: begin
                do_adjust = 1'b1;
                if (hit) begin
                    mode_next = MODE_WORKING;
                end
            end
            default: begin
                // skip a plain limit hit, act on everything else
                do_adjust = !(hit && !critical);
            end
        endcase

        freq_next = freq_reg;
        volt_next = volt_reg;
        vsel_next = vsel_reg;
        if (commit && do_adjust) begin
            freq_next = f_clamp[FREQ_W-1:0];
            volt_next = v_clamp[VOLT_W-1:0];
            vsel_next = vsel_adj;
        end else if (cfg_accept && cfg_index == CFG_START_FREQ) begin
            freq_next = cfg_data[FREQ_W-1:0];
        end else if (cfg_accept && cfg_index == CFG_START_VOLT) begin
            volt_next = cfg_data[VOLT_W-1:0];
        end
        if (!commit) begin
            mode_next  = mode_reg;
            count_next = count_reg;
        end
    end

    // result register
    always_comb begin
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (commit) begin
            out_next.frequency_out = freq_next;
            out_next.voltage_out   = volt_next;
            out_next.mode          = mode_next;
            out_next.voltage_turn  = vsel_next;
            m_valid_next           = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_accept) begin
            item_reg <= s_data;
        end
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cnt_reg         <= '0;
            m_valid_reg     <= 1'b0;
            mode_reg        <= MODE_WAIT;
            count_reg       <= COUNT_W'(WAIT_TICKS);
            vsel_reg        <= 1'b0;
            freq_reg        <= RST_START_FREQ;
            volt_reg        <= RST_START_VOLT;
            power_limit_reg <= RST_POWER_LIMIT;
            fan_limit_reg   <= RST_FAN_LIMIT;
            max_volt_reg    <= RST_MAX_VOLT;
            max_freq_reg    <= RST_MAX_FREQ;
            max_chip_t_reg  <= RST_MAX_CHIP_T;
            max_reg_t_reg   <= RST_MAX_REG_T;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
            count_reg   <= count_next;
            vsel_reg    <= vsel_next;
            freq_reg    <= freq_next;
            volt_reg    <= volt_next;
            if (cfg_accept) begin
                unique case (cfg_index)
                    // start values load straight into the working settings
                    CFG_START_FREQ, CFG_START_VOLT: ;
                    CFG_POWER_LIMIT: power_limit_reg <= cfg_data[POWER_W-1:0];
                    CFG_FAN_LIMIT:   fan_limit_reg   <= cfg_data[FAN_W-1:0];
                    CFG_MAX_VOLT:    max_volt_reg    <= cfg_data[VOLT_W-1:0];
                    CFG_MAX_FREQ:    max_freq_reg    <= cfg_data[FREQ_W-1:0];
                    CFG_MAX_CHIP_T:  max_chip_t_reg  <= $signed(cfg_data[TEMP_W-1:0]);
                    CFG_MAX_REG_T:   max_reg_t_reg   <= $signed(cfg_data[TEMP_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* rtl/fvat_cell.sv */
// ----------------------------------------------------------------------------
// fvat_cell
// One history cell: holds a hashrate, fills from a broadcast or takes its
// neighbour's value.
// ----------------------------------------------------------------------------
module fvat_cell
    import fvat_pkg::*;
(
    input  logic              aclk,
    input  logic              fill_en,
    input  logic [RATE_W-1:0] fill_val,
    input  logic              shift_en,
    input  logic [RATE_W-1:0] shift_in,
    output logic [RATE_W-1:0] data_out
);

    logic [RATE_W-1:0] data_reg;
    logic [RATE_W-1:0] data_next;

    always_comb begin
        priority if (fill_en) begin
            data_next = fill_val;
        end else if (shift_en) begin
            data_next = shift_in;
        end else begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

/* rtl/fvat_history.sv */
// ----------------------------------------------------------------------------
// fvat_history
// Hashrate history as a chain of cells, newest at the head, oldest at the
// tail. A scan rotates the chain once round and flags any entry above the
// oldest one.
// ----------------------------------------------------------------------------
module fvat_history
    import fvat_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  hist_ctrl_t        ctrl,
    input  logic [RATE_W-1:0] rate,
    output logic              rose
);

    logic [RATE_W-1:0] cell_q [HISTORY_DEPTH];
    logic [RATE_W-1:0] base_reg;
    logic [RATE_W-1:0] base_next;
    logic              rose_reg;
    logic              rose_next;
    logic              filled_reg;
    logic              filled_next;
    logic              fill_all;
    logic [RATE_W-1:0] head_in;

    // the first request after reset fills every cell
    assign fill_all = ctrl.load && !filled_reg;
    assign head_in  = ctrl.load ? rate : cell_q[HISTORY_DEPTH-1];

    generate
        for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
            if (i == 0) begin : g_head
                fvat_cell u_cell (
                    .aclk     (aclk),
                    .fill_en  (fill_all),
                    .fill_val (rate),
                    .shift_en (ctrl.load || ctrl.scan),
                    .shift_in (head_in),
                    .data_out (cell_q[i])
                );
            end else begin : g_body
                fvat_cell u_cell (
                    .aclk     (aclk),
                    .fill_en  (fill_all),
                    .fill_val (rate),
                    .shift_en (ctrl.load || ctrl.scan),
                    .shift_in (cell_q[i-1]),
                    .data_out (cell_q[i])
                );
            end
        end
    endgenerate

    always_comb begin
        base_next   = base_reg;
        rose_next   = rose_reg;
        filled_next = filled_reg;
        priority if (ctrl.load) begin
            // oldest entry once the new one is in
            base_next   = filled_reg ? cell_q[HISTORY_DEPTH-2] : rate;
            rose_next   = 1'b0;
            filled_next = 1'b1;
        end else if (ctrl.scan) begin
            rose_next = rose_reg || (cell_q[HISTORY_DEPTH-1] > base_reg);
        end else begin
            rose_next = rose_reg;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg <= base_next;
        rose_reg <= rose_next;
        if (!aresetn) begin
            filled_reg <= 1'b0;
        end else begin
            filled_reg <= filled_next;
        end
    end

    assign rose = rose_reg;

endmodule

/* rtl/fvat_checker.sv */
// ----------------------------------------------------------------------------
// fvat_checker
// Port-level checks of the auto-tuner, bound to the top level.
// ----------------------------------------------------------------------------
module fvat_checker
    import fvat_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input in_item_t              s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input out_item_t             m_data,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic [CFG_IDX_W-1:0]  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // the history scan keeps the input closed for a while after a request
    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("input reopened during scan");

    // a new result only appears at the end of a request's work
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without work");

    // configuration is always taken
    a_cfg_open: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind frequency_voltage_auto_tuner fvat_checker u_fvat_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_data    (s_data),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
